// ===== design/jsu_pkg.sv =====
// Types, character codes and helper functions for the JSON string unescaper.
// Used by the configuration block, the decoder, the result queue, the top level and the bench.
package jsu_pkg;

	typedef enum logic [1:0] {
		PH_OPEN = 2'd0,
		PH_STR  = 2'd1,
		PH_ESC  = 2'd2,
		PH_HEX  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_CLOSE    = 2'd0,
		ST_CAPACITY = 2'd1,
		ST_NO_OPEN  = 2'd2
	} status_t;

	localparam int          ADDR_W       = 3;
	localparam logic        REG_MAX_OUT  = 1'b0;
	localparam logic [15:0] MAX_OUT_RST  = 16'd256;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	localparam logic [7:0] CTL_BS  = 8'h08;
	localparam logic [7:0] CTL_FF  = 8'h0C;
	localparam logic [7:0] CTL_LF  = 8'h0A;
	localparam logic [7:0] CTL_CR  = 8'h0D;
	localparam logic [7:0] CTL_TAB = 8'h09;

	localparam logic [15:0] CP_ONE_MAX = 16'h007F;
	localparam logic [15:0] CP_TWO_MAX = 16'h07FF;
	localparam logic [15:0] CNT_SAT    = 16'hFFFF;
	localparam logic [7:0]  LEAD2      = 8'hC0;
	localparam logic [7:0]  LEAD3      = 8'hE0;
	localparam logic [7:0]  CONT       = 8'h80;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  digits;
		logic [15:0] cp;
		logic [15:0] emitted;
	} state_t;

	typedef struct packed {
		logic [2:0][7:0] data;
		logic [1:0]      cnt;
		logic            is_end;
		status_t         status;
		logic [15:0]     len;
	} bundle_t;

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

endpackage

// ===== design/jsu_if.sv =====
// Request channels of the JSON string unescaper: source bytes in, results out.
// Depends on nothing but the handshake convention valid/ready.
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        string_end;
	logic [1:0]  end_status;
	logic [15:0] decoded_length;
	logic        run_last;

	modport source (output valid, output out_byte, output string_end, output end_status,
		output decoded_length, output run_last, input ready);
	modport sink   (input valid, input out_byte, input string_end, input end_status,
		input decoded_length, input run_last, output ready);
endinterface

// ===== design/jsu_cfg.sv =====
// APB-style register block holding the output capacity.
// Depends on jsu_pkg for the address width and register index.
module jsu_cfg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [jsu_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	output logic [15:0]              max_out
);
	logic [15:0] max_out_q;
	logic        hit;

	assign pready = 1'b1;
	assign hit    = (paddr[2] == jsu_pkg::REG_MAX_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_out_q <= jsu_pkg::MAX_OUT_RST;
		end else if (psel && penable && pwrite && pready && hit) begin
			max_out_q <= pwdata[15:0];
		end
	end

	assign prdata  = hit ? {16'd0, max_out_q} : 32'd0;
	assign max_out = max_out_q;
endmodule

// ===== design/jsu_core.sv =====
// Input register, string state and single-pass decode of one source byte.
// Depends on jsu_pkg and jsu_if; hands a bundle of up to three results onward.
module jsu_core (
	input  logic             clk,
	input  logic             arst_n,
	jsu_in_if.sink           in_ch,
	input  logic [15:0]      max_out,
	input  logic             q_full,
	output logic             push,
	output jsu_pkg::bundle_t bundle
);
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             fire;
	jsu_pkg::state_t  st_q;
	jsu_pkg::state_t  st_d;
	jsu_pkg::bundle_t b;
	logic [15:0]      emit_inc;
	logic [15:0]      cp_new;
	logic [1:0]       n;
	logic [16:0]      need;
	logic [7:0]       esc_byte;
	logic             esc_hit;

	assign in_ch.ready = !valid_s1 || !q_full;
	assign fire        = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: jsu_pkg::PH_OPEN, digits: 2'd0, cp: 16'd0, emitted: 16'd0};
		end else if (fire) begin
			st_q <= st_d;
		end
	end

	assign emit_inc = (st_q.emitted == jsu_pkg::CNT_SAT) ? st_q.emitted : st_q.emitted + 16'd1;
	assign cp_new   = {st_q.cp[11:0], jsu_pkg::hex_value(byte_s1)};
	assign n        = (cp_new <= jsu_pkg::CP_ONE_MAX) ? 2'd1 :
		(cp_new <= jsu_pkg::CP_TWO_MAX) ? 2'd2 : 2'd3;
	assign need     = {1'b0, st_q.emitted} + {15'd0, n};

	always_comb begin
		esc_hit  = 1'b1;
		esc_byte = byte_s1;
		case (byte_s1)
			jsu_pkg::CH_QUOTE:  esc_byte = jsu_pkg::CH_QUOTE;
			jsu_pkg::CH_BSLASH: esc_byte = jsu_pkg::CH_BSLASH;
			jsu_pkg::CH_SLASH:  esc_byte = jsu_pkg::CH_SLASH;
			jsu_pkg::CH_B:      esc_byte = jsu_pkg::CTL_BS;
			jsu_pkg::CH_F:      esc_byte = jsu_pkg::CTL_FF;
			jsu_pkg::CH_N:      esc_byte = jsu_pkg::CTL_LF;
			jsu_pkg::CH_R:      esc_byte = jsu_pkg::CTL_CR;
			jsu_pkg::CH_T:      esc_byte = jsu_pkg::CTL_TAB;
			default:            esc_hit  = 1'b0;
		endcase
	end

	always_comb begin
		st_d = st_q;
		b    = '0;
		case (st_q.phase)
			jsu_pkg::PH_OPEN: begin
				if (byte_s1 == jsu_pkg::CH_QUOTE) begin
					st_d.phase   = jsu_pkg::PH_STR;
					st_d.emitted = 16'd0;
				end else begin
					b.cnt    = 2'd1;
					b.is_end = 1'b1;
					b.status = jsu_pkg::ST_NO_OPEN;
				end
			end
			jsu_pkg::PH_STR: begin
				if (byte_s1 == jsu_pkg::CH_QUOTE) begin
					b.cnt      = 2'd1;
					b.is_end   = 1'b1;
					b.status   = jsu_pkg::ST_CLOSE;
					b.len      = st_q.emitted;
					st_d.phase = jsu_pkg::PH_OPEN;
				end else if (st_q.emitted >= max_out) begin
					b.cnt      = 2'd1;
					b.is_end   = 1'b1;
					b.status   = jsu_pkg::ST_CAPACITY;
					b.len      = st_q.emitted;
					st_d.phase = jsu_pkg::PH_OPEN;
				end else if (byte_s1 == jsu_pkg::CH_BSLASH) begin
					st_d.phase = jsu_pkg::PH_ESC;
				end else begin
					b.cnt        = 2'd1;
					b.data[0]    = byte_s1;
					st_d.emitted = emit_inc;
				end
			end
			jsu_pkg::PH_ESC: begin
				st_d.phase = jsu_pkg::PH_STR;
				if (byte_s1 == jsu_pkg::CH_U) begin
					st_d.phase  = jsu_pkg::PH_HEX;
					st_d.digits = 2'd0;
					st_d.cp     = 16'd0;
				end else if (esc_hit) begin
					b.cnt        = 2'd1;
					b.data[0]    = esc_byte;
					st_d.emitted = emit_inc;
				end
			end
			jsu_pkg::PH_HEX: begin
				st_d.cp = cp_new;
				if (st_q.digits != 2'd3) begin
					st_d.digits = st_q.digits + 2'd1;
				end else begin
					st_d.digits = 2'd0;
					if (need >= {1'b0, max_out}) begin
						b.cnt      = 2'd1;
						b.is_end   = 1'b1;
						b.status   = jsu_pkg::ST_CAPACITY;
						b.len      = st_q.emitted;
						st_d.phase = jsu_pkg::PH_OPEN;
					end else begin
						st_d.phase   = jsu_pkg::PH_STR;
						st_d.emitted = need[15:0];
						b.cnt        = n;
						case (n)
							2'd1: b.data[0] = cp_new[7:0];
							2'd2: begin
								b.data[0] = {3'd0, cp_new[10:6]} | jsu_pkg::LEAD2;
								b.data[1] = {2'd0, cp_new[5:0]} | jsu_pkg::CONT;
							end
							default: begin
								b.data[0] = {4'd0, cp_new[15:12]} | jsu_pkg::LEAD3;
								b.data[1] = {2'd0, cp_new[11:6]} | jsu_pkg::CONT;
								b.data[2] = {2'd0, cp_new[5:0]} | jsu_pkg::CONT;
							end
						endcase
					end
				end
			end
			default: st_d = st_q;
		endcase
	end

	assign push   = fire && (b.cnt != 2'd0);
	assign bundle = b;
endmodule

// ===== design/jsu_rqueue.sv =====
// Two-entry queue of result bundles, drained one result a cycle to the output channel while out_ch.ready is high.
// Depends on jsu_pkg and jsu_if.
module jsu_rqueue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jsu_pkg::bundle_t bundle,
	output logic             full,
	jsu_out_if.source        out_ch
);
	jsu_pkg::bundle_t ent_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic [1:0]       idx_q;
	jsu_pkg::bundle_t head;
	logic             last;
	logic             pop_el;
	logic             pop_b;

	assign head   = ent_q[rd_q];
	assign full   = (cnt_q == 2'd2);
	assign last   = (idx_q == head.cnt - 2'd1);
	assign pop_el = out_ch.valid && out_ch.ready;
	assign pop_b  = pop_el && last;

	assign out_ch.valid          = (cnt_q != 2'd0);
	assign out_ch.out_byte       = head.is_end ? 8'd0 : head.data[idx_q];
	assign out_ch.string_end     = head.is_end;
	assign out_ch.end_status     = head.is_end ? head.status : jsu_pkg::ST_CLOSE;
	assign out_ch.decoded_length = head.is_end ? head.len : 16'd0;
	assign out_ch.run_last       = last;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop_b) begin
				rd_q  <= !rd_q;
				idx_q <= 2'd0;
			end else if (pop_el) begin
				idx_q <= idx_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_b};
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("result queue count overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("bundle pushed into full queue");
	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (head.cnt != 2'd0 && idx_q < head.cnt))
		else $error("head bundle index out of range");
	a_idx_wrap: assert property (@(posedge clk) disable iff (!arst_n) pop_b |=> idx_q == 2'd0)
		else $error("result index not cleared after last result");
endmodule

// ===== design/json_string_unescape_utf8.sv =====
// JSON string unescaper with UTF-8 encoding of \u escapes.
// Source bytes of a quoted string arrive one per request on in_ch, opening quote first.
// Each byte gives zero to three results on out_ch: decoded bytes, or one end result
// carrying end_status and decoded_length; run_last marks the last result of a byte.
// Capacity (max_output_bytes) sits at APB byte address 0 and resets to 256; write it
// only while no string byte is in flight.
// A byte accepted into the input register is decoded there and its results are written
// into the result queue, which offers them on out_ch; a full queue holds the byte back.
// Throughput: one byte per cycle while the result queue is not full, set by the
// single-pass decode between the input register and the two-entry result queue; a byte
// with several results holds the output until the last of them is taken.
// When out_ch stalls the queue fills, then in_ch.ready drops; nothing is lost.
// Reset clears the queue and returns to expecting an opening quote with a zero count.
// Depends on jsu_pkg, jsu_if, jsu_cfg, jsu_core and jsu_rqueue.
module json_string_unescape_utf8 (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [jsu_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	jsu_in_if.sink                     in_ch,
	jsu_out_if.source                  out_ch
);
	logic             push;
	logic             q_full;
	logic [15:0]      max_out;
	jsu_pkg::bundle_t bundle;

	jsu_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.max_out (max_out)
	);

	jsu_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.max_out (max_out),
		.q_full  (q_full),
		.push    (push),
		.bundle  (bundle)
	);

	jsu_rqueue u_rqueue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.bundle (bundle),
		.full   (q_full),
		.out_ch (out_ch)
	);
endmodule

// ===== verif/json_string_unescape_utf8_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for json_string_unescape_utf8: feeds quoted strings byte by byte,
// predicts every decoded byte and end request in step and checks the results in order.
// Depends on jsu_pkg, the jsu_in_if/jsu_out_if interfaces and the APB capacity register.
module json_string_unescape_utf8_tb;

	localparam logic [jsu_pkg::ADDR_W-1:0] CAP_ADDR   =
		jsu_pkg::ADDR_W'(4 * jsu_pkg::REG_MAX_OUT);
	localparam logic [jsu_pkg::ADDR_W-1:0] SPARE_ADDR = jsu_pkg::ADDR_W'(4);
	localparam logic [7:0] ESC_UNKNOWN = 8'h71;
	localparam logic [7:0] DIGIT_0     = 8'h30;
	localparam logic [7:0] UPPER_A     = 8'h41;
	localparam logic [7:0] LOWER_A     = 8'h61;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS   = 40;

	typedef struct {
		logic [7:0]       data;
		logic             is_end;
		jsu_pkg::status_t status;
		logic [15:0]      len;
		logic             run_last;
	} unescape_result_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [jsu_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	jsu_in_if  in_ch ();
	jsu_out_if out_ch ();

	json_string_unescape_utf8 dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	jsu_pkg::phase_t str_phase;
	logic [1:0]  hex_count;
	logic [15:0] hex_acc;
	logic [15:0] out_count;
	logic [15:0] capacity;

	unescape_result_t step_results [$];
	unescape_result_t expected_results [$];
	unescape_result_t head;

	int send_idle_pct;
	int recv_idle_pct;
	int bytes_sent;
	int results_checked;
	int strings_ended;
	int failures;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("FAILURE");
		$finish;
	end

	always @(negedge clk) begin
		out_ch.ready = arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			failures++;
			if (failures <= MAX_REPORTS)
				$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("%0t: result with none expected: expected nothing, got byte %02h end %0b len %0d",
						$time, out_ch.out_byte, out_ch.string_end, out_ch.decoded_length);
			end else begin
				head = expected_results.pop_front();
				results_checked++;
				check_field("out_byte", head.data, out_ch.out_byte);
				check_field("string_end", head.is_end, out_ch.string_end);
				check_field("end_status", head.status, out_ch.end_status);
				check_field("decoded_length", head.len, out_ch.decoded_length);
				check_field("run_last", head.run_last, out_ch.run_last);
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		step_results.push_back('{data: b, is_end: 1'b0, status: jsu_pkg::ST_CLOSE, len: 16'd0,
			run_last: 1'b0});
		if (out_count != jsu_pkg::CNT_SAT)
			out_count++;
	endtask

	task automatic push_end(input jsu_pkg::status_t st);
		logic [15:0] len;
		len = (st == jsu_pkg::ST_NO_OPEN) ? 16'd0 : out_count;
		step_results.push_back('{data: 8'd0, is_end: 1'b1, status: st, len: len, run_last: 1'b0});
		str_phase = jsu_pkg::PH_OPEN;
		strings_ended++;
	endtask

	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		if (c >= DIGIT_0 && c <= DIGIT_0 + 8'd9)
			return 4'(c - DIGIT_0);
		if (c >= LOWER_A && c <= LOWER_A + 8'd5)
			return 4'(c - LOWER_A + 8'd10);
		if (c >= UPPER_A && c <= UPPER_A + 8'd5)
			return 4'(c - UPPER_A + 8'd10);
		return 4'd0;
	endfunction

	task automatic predict_unescape(input logic [7:0] c);
		logic [15:0] cp;
		int width;
		step_results.delete();
		case (str_phase)
		jsu_pkg::PH_OPEN: begin
			if (c == jsu_pkg::CH_QUOTE) begin
				str_phase = jsu_pkg::PH_STR;
				out_count = 16'd0;
			end else begin
				push_end(jsu_pkg::ST_NO_OPEN);
			end
		end
		jsu_pkg::PH_STR: begin
			if (c == jsu_pkg::CH_QUOTE) begin
				push_end(jsu_pkg::ST_CLOSE);
			end else if (out_count >= capacity) begin
				push_end(jsu_pkg::ST_CAPACITY);
			end else if (c == jsu_pkg::CH_BSLASH) begin
				str_phase = jsu_pkg::PH_ESC;
			end else begin
				push_byte(c);
			end
		end
		jsu_pkg::PH_ESC: begin
			str_phase = jsu_pkg::PH_STR;
			case (c)
			jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: push_byte(c);
			jsu_pkg::CH_B: push_byte(jsu_pkg::CTL_BS);
			jsu_pkg::CH_F: push_byte(jsu_pkg::CTL_FF);
			jsu_pkg::CH_N: push_byte(jsu_pkg::CTL_LF);
			jsu_pkg::CH_R: push_byte(jsu_pkg::CTL_CR);
			jsu_pkg::CH_T: push_byte(jsu_pkg::CTL_TAB);
			jsu_pkg::CH_U: begin
				str_phase = jsu_pkg::PH_HEX;
				hex_count = 2'd0;
				hex_acc = 16'd0;
			end
			default: ;
			endcase
		end
		default: begin
			hex_acc = {hex_acc[11:0], nibble_of(c)};
			if (hex_count != 2'd3) begin
				hex_count++;
			end else begin
				hex_count = 2'd0;
				cp = hex_acc;
				width = (cp <= jsu_pkg::CP_ONE_MAX) ? 1 : (cp <= jsu_pkg::CP_TWO_MAX) ? 2 : 3;
				if (int'(out_count) + width >= int'(capacity)) begin
					push_end(jsu_pkg::ST_CAPACITY);
				end else begin
					str_phase = jsu_pkg::PH_STR;
					case (width)
					1: push_byte(cp[7:0]);
					2: begin
						push_byte(jsu_pkg::LEAD2 | 8'(cp[10:6]));
						push_byte(jsu_pkg::CONT | 8'(cp[5:0]));
					end
					default: begin
						push_byte(jsu_pkg::LEAD3 | 8'(cp[15:12]));
						push_byte(jsu_pkg::CONT | 8'(cp[11:6]));
						push_byte(jsu_pkg::CONT | 8'(cp[5:0]));
					end
					endcase
				end
			end
		end
		endcase
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].run_last = 1'b1;
		foreach (step_results[i])
			expected_results.push_back(step_results[i]);
	endtask

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.in_byte = b;
		do @(posedge clk); while (!in_ch.ready);
		predict_unescape(b);
		bytes_sent++;
	endtask

	task automatic send_hex_escape(input logic [7:0] d3, d2, d1, d0);
		send_byte(jsu_pkg::CH_BSLASH);
		send_byte(jsu_pkg::CH_U);
		send_byte(d3);
		send_byte(d2);
		send_byte(d1);
		send_byte(d0);
	endtask

	// hold the input low and let every outstanding request drain
	task automatic wait_idle();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [jsu_pkg::ADDR_W-1:0] addr,
		input logic [31:0] data, output logic [31:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic cfg_write(input logic [jsu_pkg::ADDR_W-1:0] addr, input logic [31:0] data);
		logic [31:0] unused;
		apb_access(1'b1, addr, data, unused);
		if (addr == CAP_ADDR)
			capacity = data[15:0];
	endtask

	task automatic check_capacity_reg();
		logic [31:0] rdata;
		apb_access(1'b0, CAP_ADDR, 32'd0, rdata);
		check_field("max_output_bytes", {16'd0, capacity}, rdata);
	endtask

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		if ($urandom_range(11) == 0)
			return 8'($urandom);
		if (n < 4'd10)
			return DIGIT_0 + 8'(n);
		return ($urandom_range(1) ? UPPER_A : LOWER_A) + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] pick_escape();
		case ($urandom_range(8))
		0: return jsu_pkg::CH_QUOTE;
		1: return jsu_pkg::CH_BSLASH;
		2: return jsu_pkg::CH_SLASH;
		3: return jsu_pkg::CH_B;
		4: return jsu_pkg::CH_F;
		5: return jsu_pkg::CH_N;
		6: return jsu_pkg::CH_R;
		7: return jsu_pkg::CH_T;
		default: return ESC_UNKNOWN;
		endcase
	endfunction

	function automatic logic [15:0] pick_capacity();
		case ($urandom_range(6))
		0: return 16'd0;
		1: return jsu_pkg::CNT_SAT;
		2: return jsu_pkg::MAX_OUT_RST;
		3: return 16'($urandom);
		default: return 16'($urandom_range(12, 1));
		endcase
	endfunction

	task automatic send_token();
		logic [15:0] cp;
		logic [7:0] b;
		case ($urandom_range(9))
		0, 1, 2, 3: begin
			do b = 8'($urandom); while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
			send_byte(b);
		end
		4, 5: begin
			send_byte(jsu_pkg::CH_BSLASH);
			send_byte(pick_escape());
		end
		6, 7, 8: begin
			case ($urandom_range(2))
			0: cp = 16'($urandom_range(jsu_pkg::CP_ONE_MAX));
			1: cp = 16'($urandom_range(jsu_pkg::CP_TWO_MAX, jsu_pkg::CP_ONE_MAX + 1));
			default: cp = 16'($urandom_range(jsu_pkg::CNT_SAT, jsu_pkg::CP_TWO_MAX + 1));
			endcase
			send_hex_escape(hex_digit(cp[15:12]), hex_digit(cp[11:8]),
				hex_digit(cp[7:4]), hex_digit(cp[3:0]));
		end
		default: begin
			// broken escape: following bytes land in the escape or hex digits
			send_byte(jsu_pkg::CH_BSLASH);
			send_byte($urandom_range(1) ? jsu_pkg::CH_U : 8'($urandom));
		end
		endcase
	endtask

	task automatic test_register_access();
		check_capacity_reg();
		cfg_write(SPARE_ADDR, 32'hFFFF_FFFF);
		check_capacity_reg();
		cfg_write(CAP_ADDR, {16'd0, jsu_pkg::CNT_SAT});
		check_capacity_reg();
		cfg_write(CAP_ADDR, {16'd0, jsu_pkg::MAX_OUT_RST});
	endtask

	task automatic test_no_opening_quote();
		send_byte(8'hFF);
	endtask

	task automatic test_simple_escapes();
		send_byte(jsu_pkg::CH_QUOTE);
		send_byte(jsu_pkg::CH_BSLASH);
		send_byte(jsu_pkg::CH_BSLASH);
		send_byte(jsu_pkg::CH_BSLASH);
		send_byte(ESC_UNKNOWN);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(jsu_pkg::CH_QUOTE);
	endtask

	task automatic test_unicode_escapes();
		send_byte(jsu_pkg::CH_QUOTE);
		send_hex_escape(DIGIT_0, DIGIT_0 + 8'd7, UPPER_A + 8'd5, LOWER_A + 8'd5);
		// quote and letters beyond f count as zero digits
		send_hex_escape(UPPER_A + 8'd5, jsu_pkg::CH_QUOTE, LOWER_A + 8'd6, UPPER_A + 8'd6);
		send_byte(jsu_pkg::CH_QUOTE);
	endtask

	task automatic test_capacity_end();
		wait_idle();
		cfg_write(CAP_ADDR, 32'd1);
		send_byte(jsu_pkg::CH_QUOTE);
		send_byte(LOWER_A);
		send_byte(LOWER_A + 8'd1);
		wait_idle();
		cfg_write(CAP_ADDR, 32'd0);
		send_byte(jsu_pkg::CH_QUOTE);
		send_byte(LOWER_A + 8'd23);
	endtask

	task automatic test_escape_at_capacity();
		wait_idle();
		cfg_write(CAP_ADDR, {16'd0, jsu_pkg::MAX_OUT_RST});
		send_byte(jsu_pkg::CH_QUOTE);
		send_byte(jsu_pkg::CH_BSLASH);
		wait_idle();
		cfg_write(CAP_ADDR, 32'd0);
		send_byte(jsu_pkg::CH_N);
		send_byte(jsu_pkg::CH_QUOTE);
	endtask

	task automatic test_random_strings(input int send_pct, input int recv_pct, input int n_bytes);
		int stop_at;
		int tokens;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(3) == 0) begin
				wait_idle();
				cfg_write(CAP_ADDR, {16'd0, pick_capacity()});
			end
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
			end else begin
				send_byte(jsu_pkg::CH_QUOTE);
				tokens = $urandom_range(10);
				repeat (tokens) send_token();
				if ($urandom_range(9) != 0)
					send_byte(jsu_pkg::CH_QUOTE);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'd0;
		out_ch.ready = 1'b0;
		str_phase = jsu_pkg::PH_OPEN;
		hex_count = 2'd0;
		hex_acc = 16'd0;
		out_count = 16'd0;
		capacity = jsu_pkg::MAX_OUT_RST;
		send_idle_pct = 0;
		recv_idle_pct = 30;
		bytes_sent = 0;
		results_checked = 0;
		strings_ended = 0;
		failures = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_access();
		test_no_opening_quote();
		test_simple_escapes();
		test_unicode_escapes();
		test_capacity_end();
		test_escape_at_capacity();
		test_random_strings(12, 81, 100);
		test_random_strings(81, 12, 100);
		test_random_strings(0, 0, 100);

		wait_idle();
		check_capacity_reg();
		$display("Sent %0d source bytes, checked %0d results over %0d string ends,",
			bytes_sent, results_checked, strings_ended);
		$display("with capacities from 0 to 65535 and three stall mixes on both channels.");
		if (failures == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== json_string_unescape_utf8.f =====
design/jsu_pkg.sv
design/jsu_if.sv
design/jsu_cfg.sv
design/jsu_core.sv
design/jsu_rqueue.sv
design/json_string_unescape_utf8.sv
verif/json_string_unescape_utf8_tb.sv
